FILE: src/iats_pkg.sv
// Shared types and constants for the integrating converter tick sequencer.
// Holds the beat structs, configuration struct, phase enum and code values.
// No dependencies.
package iats_pkg;

  localparam int CYCLE_LENGTH = 20;
  localparam int CYCLE_W      = $clog2(CYCLE_LENGTH);

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_INTEGRATION_TICKS = 3'd0;
  localparam logic [2:0] REG_CAPTURE_TIMEOUT   = 3'd1;
  localparam logic [2:0] REG_COUNT_MIN         = 3'd2;
  localparam logic [2:0] REG_COUNT_MAX         = 3'd3;
  localparam logic [2:0] REG_MIN_PERIOD_TICKS  = 3'd4;

  localparam logic [7:0]  RST_INTEGRATION_TICKS = 8'd250;
  localparam logic [7:0]  RST_CAPTURE_TIMEOUT   = 8'd50;
  localparam logic [7:0]  RST_COUNT_MIN         = 8'd15;
  localparam logic [7:0]  RST_COUNT_MAX         = 8'd235;
  localparam logic [19:0] RST_MIN_PERIOD_TICKS  = 20'd375000;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic CH_AUTOZERO = 1'b0;
  localparam logic CH_MEASURE  = 1'b1;

  typedef enum logic [1:0] {
    PH_SELECT       = 2'd0,
    PH_INTEGRATE    = 2'd1,
    PH_WAIT_COMP    = 2'd2,
    PH_WAIT_CAPTURE = 2'd3
  } phase_t;

  typedef struct packed {
    logic        comparator_level;
    logic        capture_flag;
    logic [15:0] capture_time;
    logic [15:0] timer_now;
    logic        settled;
  } tick_in_t;

  typedef struct packed {
    logic        select_strobe;
    logic        select_channel;
    logic        sample_valid;
    logic [1:0]  sample_status;
    logic        sample_channel;
    logic [7:0]  low_count;
    logic [20:0] period_ticks;
    logic [15:0] start_time;
  } tick_out_t;

  typedef struct packed {
    logic [7:0]  integration_ticks;
    logic [7:0]  capture_timeout;
    logic [7:0]  count_min;
    logic [7:0]  count_max;
    logic [19:0] min_period_ticks;
  } cfg_t;

endpackage

FILE: src/integrating_adc_tick_sequencer_core.sv
// Top level of the integrating converter tick sequencer.
// Depends on iats_pkg, iats_regs (configuration) and iats_step (sequencer).
//
// Usage:
//   Each input beat on in_data is one timer tick: comparator level, capture
//   flag and time, current timer value and the settled flag. Every accepted
//   tick yields exactly one output beat on out_data carrying the multiplexer
//   strobe and channel and, when sample_valid is set, one finished sample.
//   A beat moves when valid is high and stall is low.
//   An accepted tick is held in the input register and passes through the
//   sequencer logic into the output register, which raises out_valid.
//   Throughput is one tick per cycle while out_stall does not hold the
//   output register full, set by the single sequencer pass between the two.
//   When out_stall holds the output register full, the pending tick waits in
//   the input register and in_stall rises only while that register is full
//   and cannot advance.
//   Reset (rst, synchronous) empties both registers, returns the sequencer
//   to channel select on autozero with all counters cleared, and loads the
//   configuration reset values. The user must write registers through the
//   APB-style port only while the block is idle; the block does not enforce it.
module integrating_adc_tick_sequencer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  iats_pkg::tick_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output iats_pkg::tick_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iats_pkg::ADDR_W-1:0] paddr,
  input  logic [iats_pkg::DATA_W-1:0] pwdata,
  output logic [iats_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import iats_pkg::*;

  cfg_t      cfg;
  logic      tick_valid;
  tick_in_t  tick;
  tick_out_t result;
  logic      out_free;
  logic      fire;

  assign out_free = !out_valid || !out_stall;
  assign fire     = tick_valid && out_free;
  assign in_stall = tick_valid && !out_free;

  iats_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iats_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .tick   (tick),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!in_stall) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      tick <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

endmodule

FILE: src/iats_regs.sv
// APB-style configuration register file for the tick sequencer.
// Depends on iats_pkg for the register map, reset values and cfg_t.
module iats_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [iats_pkg::ADDR_W-1:0] paddr,
  input  logic [iats_pkg::DATA_W-1:0] pwdata,
  output logic [iats_pkg::DATA_W-1:0] prdata,
  output logic                   pready,
  output iats_pkg::cfg_t         cfg
);
  import iats_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.integration_ticks <= RST_INTEGRATION_TICKS;
      cfg.capture_timeout   <= RST_CAPTURE_TIMEOUT;
      cfg.count_min         <= RST_COUNT_MIN;
      cfg.count_max         <= RST_COUNT_MAX;
      cfg.min_period_ticks  <= RST_MIN_PERIOD_TICKS;
    end else if (wr_en) begin
      case (reg_index)
        REG_INTEGRATION_TICKS: cfg.integration_ticks <= pwdata[7:0];
        REG_CAPTURE_TIMEOUT:   cfg.capture_timeout   <= pwdata[7:0];
        REG_COUNT_MIN:         cfg.count_min         <= pwdata[7:0];
        REG_COUNT_MAX:         cfg.count_max         <= pwdata[7:0];
        REG_MIN_PERIOD_TICKS:  cfg.min_period_ticks  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_INTEGRATION_TICKS: prdata = {24'd0, cfg.integration_ticks};
      REG_CAPTURE_TIMEOUT:   prdata = {24'd0, cfg.capture_timeout};
      REG_COUNT_MIN:         prdata = {24'd0, cfg.count_min};
      REG_COUNT_MAX:         prdata = {24'd0, cfg.count_max};
      REG_MIN_PERIOD_TICKS:  prdata = {12'd0, cfg.min_period_ticks};
      default:               prdata = '0;
    endcase
  end

endmodule

FILE: src/iats_step.sv
// Sequencer state and per-tick next-state logic of the tick sequencer.
// Depends on iats_pkg for phase_t, the beat structs and cfg_t.
module iats_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  iats_pkg::tick_in_t  tick,
  input  iats_pkg::cfg_t      cfg,
  output iats_pkg::tick_out_t result
);
  import iats_pkg::*;

  phase_t             phase, phase_next;
  logic [7:0]         delay_count, delay_count_next;
  logic               current_channel, current_channel_next;
  logic [CYCLE_W-1:0] cycle_index, cycle_index_next;
  logic [7:0]         low_tick_count, low_tick_count_next;
  logic [15:0]        last_start, last_start_next;
  logic [20:0]        last_period, last_period_next;
  logic [7:0]         last_count, last_count_next;

  logic [7:0]  delay_dec;
  logic        delay_zero;
  logic        timeout;
  logic        captured;
  logic        send;
  logic [15:0] raw_diff;
  logic [19:0] short_by;
  logic [20:0] short_round;
  logic [20:0] ext_period;
  logic [7:0]  low_base;

  assign delay_dec  = delay_count - 8'd1;
  assign delay_zero = (delay_dec == 8'd0);
  assign timeout    = (phase == PH_WAIT_CAPTURE) && delay_zero;
  assign captured   = (phase == PH_WAIT_CAPTURE) && !delay_zero
                      && tick.capture_flag && !tick.comparator_level;
  assign send       = timeout || captured;

  assign raw_diff    = tick.capture_time - last_start;
  assign short_by    = cfg.min_period_ticks - {4'd0, raw_diff};
  assign short_round = {1'b0, short_by} + 21'd65535;
  assign ext_period  = ({4'd0, raw_diff} < cfg.min_period_ticks)
                       ? {short_round[20:16], raw_diff} : {5'd0, raw_diff};

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SELECT:       phase_next = PH_INTEGRATE;
      PH_INTEGRATE:    if (delay_zero) phase_next = PH_WAIT_COMP;
      PH_WAIT_COMP:    if (tick.comparator_level || delay_zero) phase_next = PH_WAIT_CAPTURE;
      PH_WAIT_CAPTURE: if (send) phase_next = PH_SELECT;
      default:         phase_next = PH_SELECT;
    endcase
  end

  always_comb begin
    delay_count_next     = delay_dec;
    current_channel_next = current_channel;
    cycle_index_next     = cycle_index;
    last_start_next      = last_start;
    last_period_next     = last_period;
    last_count_next      = last_count;
    result               = '0;

    case (phase)
      PH_SELECT: begin
        result.select_strobe  = 1'b1;
        result.select_channel = current_channel;
        delay_count_next      = cfg.integration_ticks;
      end
      PH_INTEGRATE: begin
        if (delay_zero) begin
          result.select_strobe  = 1'b1;
          result.select_channel = CH_AUTOZERO;
          delay_count_next      = cfg.capture_timeout;
        end
      end
      default: ;
    endcase

    if (timeout) begin
      last_start_next = tick.timer_now;
    end else if (captured) begin
      last_period_next = ext_period;
      last_start_next  = tick.capture_time;
      last_count_next  = low_tick_count;
    end

    if (send) begin
      if (tick.settled) begin
        cycle_index_next = (cycle_index == CYCLE_W'(CYCLE_LENGTH - 1))
                           ? '0 : cycle_index + CYCLE_W'(1);
        current_channel_next = (cycle_index_next == '0) ? CH_AUTOZERO : CH_MEASURE;
      end else begin
        current_channel_next = !current_channel;
      end
      result.sample_valid   = 1'b1;
      result.sample_channel = current_channel;
      result.low_count      = last_count_next;
      result.period_ticks   = last_period_next;
      result.start_time     = last_start_next;
      if (timeout) begin
        result.sample_status = ST_TIMEOUT;
      end else if (last_count_next >= cfg.count_min && last_count_next <= cfg.count_max) begin
        result.sample_status = ST_READY;
      end else begin
        result.sample_status = ST_RANGE;
      end
    end
  end

  assign low_base            = send ? 8'd0 : low_tick_count;
  assign low_tick_count_next = low_base + {7'd0, !tick.comparator_level};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SELECT;
      delay_count     <= '0;
      current_channel <= CH_AUTOZERO;
      cycle_index     <= '0;
      low_tick_count  <= '0;
      last_start      <= '0;
      last_period     <= '0;
      last_count      <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      delay_count     <= delay_count_next;
      current_channel <= current_channel_next;
      cycle_index     <= cycle_index_next;
      low_tick_count  <= low_tick_count_next;
      last_start      <= last_start_next;
      last_period     <= last_period_next;
      last_count      <= last_count_next;
    end
  end

endmodule

FILE: bench/tick_sample_checker.sv
// Checker for the integrating converter tick sequencer: predicts every output beat
// from the accepted ticks and the register writes it sees, then compares field by field.
// Depends on iats_pkg for the beat structs, phase enum and code values.
module tick_sample_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  iats_pkg::tick_in_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  iats_pkg::tick_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [iats_pkg::ADDR_W-1:0] paddr,
  input  logic [iats_pkg::DATA_W-1:0] pwdata,
  output int                          outstanding,
  output int                          mismatches
);
  import iats_pkg::*;

  cfg_t                cfg;
  phase_t              seq_phase;
  logic [7:0]          delay_left;
  logic                chan;
  logic [CYCLE_W-1:0]  cycle_pos;
  logic [7:0]          low_ticks;
  logic [15:0]         prev_start;
  logic [20:0]         prev_period;
  logic [7:0]          prev_count;
  tick_out_t           predicted_outputs[$];
  tick_out_t           want;

  function automatic logic [20:0] stretch_period(logic [15:0] diff);
    int unsigned p;
    int unsigned steps;
    p = {16'd0, diff};
    if (p < {12'd0, cfg.min_period_ticks}) begin
      steps = ({12'd0, cfg.min_period_ticks} - p + 32'd65535) >> 16;
      p = p + (steps << 16);
    end
    return p[20:0];
  endfunction

  function automatic tick_out_t step_sequencer(tick_in_t t);
    tick_out_t  r;
    logic       fire;
    logic [1:0] status;
    r = '0;
    fire = 1'b0;
    status = ST_READY;
    delay_left = delay_left - 8'd1;
    case (seq_phase)
      PH_SELECT: begin
        r.select_strobe = 1'b1;
        r.select_channel = chan;
        delay_left = cfg.integration_ticks;
        seq_phase = PH_INTEGRATE;
      end
      PH_INTEGRATE: begin
        if (delay_left == 8'd0) begin
          r.select_strobe = 1'b1;
          r.select_channel = CH_AUTOZERO;
          seq_phase = PH_WAIT_COMP;
          delay_left = cfg.capture_timeout;
        end
      end
      PH_WAIT_COMP: begin
        if (t.comparator_level || delay_left == 8'd0) seq_phase = PH_WAIT_CAPTURE;
      end
      default: begin
        if (delay_left == 8'd0) begin
          prev_start = t.timer_now;
          status = ST_TIMEOUT;
          fire = 1'b1;
        end else if (t.capture_flag && !t.comparator_level) begin
          prev_period = stretch_period(t.capture_time - prev_start);
          prev_start = t.capture_time;
          prev_count = low_ticks;
          status = (prev_count >= cfg.count_min && prev_count <= cfg.count_max) ?
                   ST_READY : ST_RANGE;
          fire = 1'b1;
        end
        if (fire) begin
          r.sample_valid = 1'b1;
          r.sample_status = status;
          r.sample_channel = chan;
          r.low_count = prev_count;
          r.period_ticks = prev_period;
          r.start_time = prev_start;
          if (t.settled) begin
            cycle_pos = (cycle_pos == CYCLE_W'(CYCLE_LENGTH - 1)) ?
                        '0 : cycle_pos + CYCLE_W'(1);
            chan = (cycle_pos == '0) ? CH_AUTOZERO : CH_MEASURE;
          end else begin
            chan = ~chan;
          end
          seq_phase = PH_SELECT;
          low_ticks = 8'd0;
        end
      end
    endcase
    if (!t.comparator_level) low_ticks = low_ticks + 8'd1;
    return r;
  endfunction

  task automatic check_field(string field, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t checker: %s expected %0h got %0h", $time, field, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.integration_ticks = RST_INTEGRATION_TICKS;
      cfg.capture_timeout = RST_CAPTURE_TIMEOUT;
      cfg.count_min = RST_COUNT_MIN;
      cfg.count_max = RST_COUNT_MAX;
      cfg.min_period_ticks = RST_MIN_PERIOD_TICKS;
      seq_phase = PH_SELECT;
      delay_left = '0;
      chan = CH_AUTOZERO;
      cycle_pos = '0;
      low_ticks = '0;
      prev_start = '0;
      prev_period = '0;
      prev_count = '0;
      predicted_outputs.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_INTEGRATION_TICKS: cfg.integration_ticks = pwdata[7:0];
          REG_CAPTURE_TIMEOUT:   cfg.capture_timeout = pwdata[7:0];
          REG_COUNT_MIN:         cfg.count_min = pwdata[7:0];
          REG_COUNT_MAX:         cfg.count_max = pwdata[7:0];
          REG_MIN_PERIOD_TICKS:  cfg.min_period_ticks = pwdata[19:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          $display("%0t checker: expected no beat got %0h", $time, out_data);
          mismatches++;
        end else begin
          want = predicted_outputs.pop_front();
          check_field("select_strobe", want.select_strobe, out_data.select_strobe);
          check_field("select_channel", want.select_channel, out_data.select_channel);
          check_field("sample_valid", want.sample_valid, out_data.sample_valid);
          check_field("sample_status", want.sample_status, out_data.sample_status);
          check_field("sample_channel", want.sample_channel, out_data.sample_channel);
          check_field("low_count", want.low_count, out_data.low_count);
          check_field("period_ticks", want.period_ticks, out_data.period_ticks);
          check_field("start_time", want.start_time, out_data.start_time);
        end
      end
      if (in_valid && !in_stall) predicted_outputs.push_back(step_sequencer(in_data));
      outstanding <= predicted_outputs.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the tick sequencer bench: clock, reset, tick stimulus, register writes, verdict.
// Depends on iats_pkg, integrating_adc_tick_sequencer_core and tick_sample_checker.
module testbench;
  import iats_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef enum int {SETTLE_NEVER, SETTLE_ALWAYS, SETTLE_RANDOM} settle_mode_t;

  typedef struct {
    cfg_t         cfg;
    int           ticks;
    int           level_high_pct;
    int           capture_pct;
    settle_mode_t settle_mode;
  } run_plan_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  tick_in_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  tick_out_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                outstanding;
  int                mismatches;
  int                quiet_cycles = 0;
  logic              steady = 1'b0;

  always #5 clk = ~clk;

  integrating_adc_tick_sequencer_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tick_sample_checker sample_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < 15);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tick_in_t mk_tick(logic level, logic cap, logic [15:0] cap_time,
                                       logic [15:0] now, logic settled);
    tick_in_t t;
    t.comparator_level = level;
    t.capture_flag = cap;
    t.capture_time = cap_time;
    t.timer_now = now;
    t.settled = settled;
    return t;
  endfunction

  function automatic run_plan_t mk_plan(int integ, int tmo, int cmin, int cmax, int minp,
                                        int ticks, int lvl, int cap, settle_mode_t mode);
    run_plan_t p;
    p.cfg.integration_ticks = 8'(integ);
    p.cfg.capture_timeout = 8'(tmo);
    p.cfg.count_min = 8'(cmin);
    p.cfg.count_max = 8'(cmax);
    p.cfg.min_period_ticks = 20'(minp);
    p.ticks = ticks;
    p.level_high_pct = lvl;
    p.capture_pct = cap;
    p.settle_mode = mode;
    return p;
  endfunction

  task automatic push_tick(tick_in_t t);
    while (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(REG_INTEGRATION_TICKS, DATA_W'(c.integration_ticks));
    write_reg(REG_CAPTURE_TIMEOUT, DATA_W'(c.capture_timeout));
    write_reg(REG_COUNT_MIN, DATA_W'(c.count_min));
    write_reg(REG_COUNT_MAX, DATA_W'(c.count_max));
    write_reg(REG_MIN_PERIOD_TICKS, DATA_W'(c.min_period_ticks));
  endtask

  task automatic drain_samples();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    run_plan_t plans[5];
    run_plan_t first;
    tick_in_t  t;
    plans[0] = mk_plan(3, 10, 2, 5, 1, 250, 30, 35, SETTLE_ALWAYS);
    plans[1] = mk_plan(1, 1, 255, 255, 1048575, 150, 50, 50, SETTLE_RANDOM);
    plans[2] = mk_plan(0, 4, 200, 100, 65536, 250, 20, 30, SETTLE_NEVER);
    plans[3] = mk_plan(255, 255, 0, 0, 0, 330, 3, 5, SETTLE_NEVER);
    plans[4] = mk_plan(8, 2, 15, 235, 375000, 100, 40, 10, SETTLE_RANDOM);
    first = mk_plan(2, 6, 0, 255, 0, 0, 0, 0, SETTLE_NEVER);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apply_config(first.cfg);
    push_tick(mk_tick(0, 1, 16'hFFFF, 16'h0000, 0));
    push_tick(mk_tick(0, 0, 16'h0000, 16'hFFFF, 0));
    push_tick(mk_tick(0, 0, 16'h0000, 16'h0000, 0));
    push_tick(mk_tick(0, 1, 16'h0100, 16'h0001, 0));
    push_tick(mk_tick(1, 0, 16'h0000, 16'h0002, 0));
    push_tick(mk_tick(1, 1, 16'h0200, 16'h0003, 0));
    push_tick(mk_tick(0, 1, 16'hFFFF, 16'h5555, 0));
    push_tick(mk_tick(0, 0, 16'h0000, 16'h0000, 0));
    push_tick(mk_tick(0, 0, 16'h0000, 16'h0000, 0));
    push_tick(mk_tick(0, 0, 16'h0000, 16'h0000, 0));
    push_tick(mk_tick(1, 0, 16'h0000, 16'h0000, 0));
    push_tick(mk_tick(1, 0, 16'hAAAA, 16'h0000, 0));
    push_tick(mk_tick(1, 0, 16'h0000, 16'h0000, 0));
    push_tick(mk_tick(1, 0, 16'h0000, 16'h0000, 0));
    push_tick(mk_tick(1, 0, 16'h0000, 16'h0000, 1));
    push_tick(mk_tick(1, 0, 16'h0000, 16'hFFFF, 1));
    push_tick(mk_tick(0, 0, 16'h0000, 16'h0000, 1));
    push_tick(mk_tick(0, 0, 16'h0000, 16'h0000, 1));
    push_tick(mk_tick(0, 0, 16'h0000, 16'h0000, 1));
    push_tick(mk_tick(1, 1, 16'h0000, 16'h0000, 1));
    push_tick(mk_tick(0, 1, 16'h0000, 16'h1234, 1));
    drain_samples();

    foreach (plans[p]) begin
      apply_config(plans[p].cfg);
      for (int k = 0; k < plans[p].ticks; k++) begin
        steady = (p == 0) && (k >= 60) && (k < 180);
        t.comparator_level = $urandom_range(99) < plans[p].level_high_pct;
        t.capture_flag = $urandom_range(99) < plans[p].capture_pct;
        t.capture_time = 16'($urandom);
        t.timer_now = 16'($urandom);
        case (plans[p].settle_mode)
          SETTLE_NEVER:  t.settled = 1'b0;
          SETTLE_ALWAYS: t.settled = 1'b1;
          default:       t.settled = 1'($urandom_range(1));
        endcase
        push_tick(t);
      end
      steady = 1'b0;
      drain_samples();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
